/* hw/rtl/hdwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hdwc_pkg;

  // Divider geometry: numerators up to 33 bits, denominators up to 40*65535.
  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 22;
  localparam int unsigned CntW = $clog2(NumW + 1);

  localparam logic [15:0] CmQ16    = 16'd655;
  localparam logic [12:0] LimitQ88 = 13'd5120;
  localparam logic [16:0] WOne     = 17'd65536;

  // Steering modes
  localparam logic [1:0] MODE_FWD   = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  // Register indexes
  localparam logic [3:0] REG_THRESH = 4'd0;
  localparam logic [3:0] REG_FWD    = 4'd1;
  localparam logic [3:0] REG_LTURN  = 4'd2;
  localparam logic [3:0] REG_RTURN  = 4'd3;
  localparam logic [3:0] REG_SLOPE  = 4'd4;
  localparam logic [3:0] REG_ICPT   = 4'd5;
  localparam logic [3:0] REG_RADIUS = 4'd6;
  localparam logic [3:0] REG_TRACK  = 4'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DIFF,
    OP_MUL_SUM,
    OP_DIV_ANG,
    OP_AVG,
    OP_LIN_GO,
    OP_DIV_LIN,
    OP_AT_GO,
    OP_DIV_AT,
    OP_MUL_WL,
    OP_MUL_WA,
    OP_W_MAX,
    OP_MUL_EXT,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic accept;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/hdwc_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module hdwc_divider
  import hdwc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quot_o
);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   rem_sh;
  logic            qbit;

  // One quotient bit per cycle, restoring.
  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      num_d  = {num_q[NumW-2:0], qbit};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

/* hw/rtl/hdwc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module hdwc_datapath
  import hdwc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_status_t       status_o,
  input  wire logic [47:0] in_data_i,
  output logic      [55:0] out_data_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0] thr_q;
  logic [15:0] fwd_q, slope_q, icpt_q, radius_q, track_q;
  logic [31:0] lts_q, rts_q;

  logic signed [15:0] yaw_q;
  logic        [14:0] lin_q;
  logic        [1:0]  mode_q, mode_d;
  logic        [15:0] ang_avg_q, lin_avg_q, prev_l_q, prev_r_q;
  logic signed [47:0] prod_q;
  logic               ang_neg_q;
  logic signed [17:0] exp_lin_q;
  logic        [27:0] lin_sc_q, ang_sc_q;
  logic        [16:0] wl_q, w_q;
  logic               out_valid_q;
  logic        [55:0] out_data_q;

  logic [15:0] r_eff, t_eff, maxw;
  logic signed [17:0] mul_a;
  logic signed [29:0] mul_b;
  logic [47:0] prod_mag;
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;
  logic signed [15:0] th_fl, th_fr, th_lf, th_rf, in_angle;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      fwd_q    <= '0;
      lts_q    <= '0;
      rts_q    <= '0;
      slope_q  <= 16'd256;
      icpt_q   <= '0;
      radius_q <= 16'd3277;
      track_q  <= 16'd9830;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESH: thr_q    <= cfg_data_i;
        REG_FWD:    fwd_q    <= cfg_data_i[15:0];
        REG_LTURN:  lts_q    <= cfg_data_i[31:0];
        REG_RTURN:  rts_q    <= cfg_data_i[31:0];
        REG_SLOPE:  slope_q  <= cfg_data_i[15:0];
        REG_ICPT:   icpt_q   <= cfg_data_i[15:0];
        REG_RADIUS: radius_q <= cfg_data_i[15:0];
        REG_TRACK:  track_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign r_eff = (radius_q == '0) ? 16'd1 : radius_q;
  assign t_eff = (track_q == '0) ? 16'd1 : track_q;
  assign maxw  = (r_eff < CmQ16) ? 16'd0 : 16'(r_eff - CmQ16);

  // Steering transition, evaluated on the incoming angle
  assign in_angle = in_data_i[15:0];
  assign th_fl = thr_q[15:0];
  assign th_fr = thr_q[31:16];
  assign th_lf = thr_q[47:32];
  assign th_rf = thr_q[63:48];
  always_comb begin
    case (mode_q)
      MODE_LEFT:  mode_d = (in_angle < th_lf) ? MODE_FWD : MODE_LEFT;
      MODE_RIGHT: mode_d = (in_angle > th_rf) ? MODE_FWD : MODE_RIGHT;
      default: begin
        if (in_angle > th_fl)      mode_d = MODE_LEFT;
        else if (in_angle < th_fr) mode_d = MODE_RIGHT;
        else                       mode_d = MODE_FWD;
      end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_DIFF: begin
        mul_a = 18'($signed(prev_l_q)) - 18'($signed(prev_r_q));
        mul_b = {14'd0, r_eff};
      end
      OP_MUL_SUM: begin
        mul_a = 18'($signed(prev_l_q)) + 18'($signed(prev_r_q));
        mul_b = {14'd0, r_eff};
      end
      OP_LIN_GO: begin
        mul_a = {2'd0, ang_avg_q};
        mul_b = {14'd0, t_eff};
      end
      OP_MUL_WL: begin
        mul_a = 18'($signed(slope_q));
        mul_b = {2'd0, lin_sc_q};
      end
      OP_MUL_WA: begin
        mul_a = 18'($signed(slope_q));
        mul_b = {2'd0, ang_sc_q};
      end
      OP_MUL_EXT: begin
        mul_a = {1'b0, w_q};
        mul_b = {14'd0, maxw};
      end
      default: ;
    endcase
  end

  assign prod_mag = prod_q[47] ? 48'(-prod_q) : 48'(prod_q);

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.op)
      OP_MUL_SUM: begin
        div_start = 1'b1;
        div_num   = prod_mag[NumW-1:0] + NumW'(t_eff[15:1]);
        div_den   = DenW'(t_eff);
      end
      OP_LIN_GO: begin
        div_start = 1'b1;
        div_num   = {1'b0, lin_avg_q, 16'd0};
        div_den   = (DenW'(r_eff) << 4) + (DenW'(r_eff) << 2);
      end
      OP_AT_GO: begin
        div_start = 1'b1;
        div_num   = prod_q[NumW-1:0];
        div_den   = (DenW'(r_eff) << 5) + (DenW'(r_eff) << 3);
      end
      default: ;
    endcase
  end

  hdwc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  function automatic logic [16:0] weg_clamp(input logic signed [47:0] p,
                                            input logic [15:0] icpt);
    logic signed [47:0] v;
    v = p + (48'($signed(icpt)) <<< 8);
    if (v < 0)                        weg_clamp = '0;
    else if (v > $signed({31'd0, WOne})) weg_clamp = WOne;
    else                              weg_clamp = v[16:0];
  endfunction

  // Error averaging terms, wheel command limits and the extension setpoint
  logic signed [34:0] exp_ang;
  logic signed [35:0] ang_diff, ang_abs;
  logic signed [18:0] lin_diff, lin_abs;
  logic        [15:0] ang_err, lin_err;
  logic        [33:0] lin_round;
  logic        [16:0] wa;
  logic        [12:0] lim;
  logic signed [15:0] lim_s, cmd_l, cmd_r, cl, cr;
  logic        [47:0] ext_sum;
  logic        [15:0] ext;

  always_comb begin
    exp_ang   = ang_neg_q ? -$signed({2'b0, div_quot}) : $signed({2'b0, div_quot});
    ang_diff  = 36'(yaw_q) - 36'(exp_ang);
    ang_abs   = ang_diff[35] ? -ang_diff : ang_diff;
    ang_err   = (ang_abs > 36'sd65535) ? 16'hFFFF : ang_abs[15:0];
    lin_diff  = $signed({4'd0, lin_q}) - 19'(exp_lin_q);
    lin_abs   = lin_diff[18] ? -lin_diff : lin_diff;
    lin_err   = (lin_abs > 19'sd65535) ? 16'hFFFF : lin_abs[15:0];
    lin_round = {1'b0, prod_mag[32:0]} + 34'd65536;
    wa        = weg_clamp(prod_q, icpt_q);
    lim       = LimitQ88 - w_q[16:4];
    lim_s     = $signed({3'd0, lim});
    case (mode_q)
      MODE_LEFT: begin
        cmd_l = lts_q[15:0];
        cmd_r = lts_q[31:16];
      end
      MODE_RIGHT: begin
        cmd_l = rts_q[15:0];
        cmd_r = rts_q[31:16];
      end
      default: begin
        cmd_l = fwd_q;
        cmd_r = fwd_q;
      end
    endcase
    cl = (cmd_l > lim_s) ? lim_s : ((cmd_l < -lim_s) ? -lim_s : cmd_l);
    cr = (cmd_r > lim_s) ? lim_s : ((cmd_r < -lim_s) ? -lim_s : cmd_r);
    ext_sum = 48'(prod_q) + 48'd32768;
    ext     = (ext_sum[47:32] != '0) ? 16'hFFFF : ext_sum[31:16];
  end

  // State that the reset defines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FWD;
      ang_avg_q   <= '0;
      lin_avg_q   <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) mode_q <= mode_d;
      if (cmd_i.op == OP_AVG) begin
        ang_avg_q <= 16'(({2'd0, ang_err} + {1'b0, ang_avg_q, 1'b0} + {2'd0, ang_avg_q}) >> 2);
        lin_avg_q <= 16'(({2'd0, lin_err} + {1'b0, lin_avg_q, 1'b0} + {2'd0, lin_avg_q}) >> 2);
      end
      if (cmd_i.op == OP_FIN && status_o.out_free) begin
        prev_l_q    <= cl;
        prev_r_q    <= cr;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lin_q   <= in_data_i[30:16];
      yaw_q   <= in_data_i[46:31];
    end
    case (cmd_i.op)
      OP_MUL_DIFF, OP_MUL_SUM, OP_LIN_GO, OP_MUL_WL, OP_MUL_WA, OP_MUL_EXT:
        prod_q <= mul_a * mul_b;
      default: ;
    endcase
    if (cmd_i.op == OP_MUL_SUM) ang_neg_q <= prod_q[47];
    if (cmd_i.op == OP_DIV_ANG) begin
      // expected speed is the negated wheel sum, so the sign flips
      exp_lin_q <= prod_q[47] ? $signed({2'b0, lin_round[32:17]})
                              : -$signed({2'b0, lin_round[32:17]});
    end
    if (cmd_i.op == OP_DIV_LIN && div_done) lin_sc_q <= div_quot[27:0];
    if (cmd_i.op == OP_DIV_AT && div_done)  ang_sc_q <= div_quot[27:0];
    if (cmd_i.op == OP_MUL_WA) wl_q <= wa;
    if (cmd_i.op == OP_W_MAX)  w_q  <= (wa > wl_q) ? wa : wl_q;
    if (cmd_i.op == OP_FIN && status_o.out_free)
      out_data_q <= {6'd0, ext, cr, cl, mode_q};
  end

  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

/* hw/rtl/hdwc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module hdwc_ctrl
  import hdwc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_MUL_DIFF = 14'b00000000000010,
    S_MUL_SUM  = 14'b00000000000100,
    S_DIV_ANG  = 14'b00000000001000,
    S_AVG      = 14'b00000000010000,
    S_LIN_GO   = 14'b00000000100000,
    S_DIV_LIN  = 14'b00000001000000,
    S_AT_GO    = 14'b00000010000000,
    S_DIV_AT   = 14'b00000100000000,
    S_MUL_WL   = 14'b00001000000000,
    S_MUL_WA   = 14'b00010000000000,
    S_W_MAX    = 14'b00100000000000,
    S_MUL_EXT  = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.accept = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.op     = OP_LOAD;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_MUL_DIFF;
      end
      S_MUL_DIFF: begin
        cmd_o.op = OP_MUL_DIFF;
        state_d  = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        cmd_o.op = OP_MUL_SUM;
        state_d  = S_DIV_ANG;
      end
      S_DIV_ANG: begin
        cmd_o.op = OP_DIV_ANG;
        if (status_i.div_done) state_d = S_AVG;
      end
      S_AVG: begin
        cmd_o.op = OP_AVG;
        state_d  = S_LIN_GO;
      end
      S_LIN_GO: begin
        cmd_o.op = OP_LIN_GO;
        state_d  = S_DIV_LIN;
      end
      S_DIV_LIN: begin
        cmd_o.op = OP_DIV_LIN;
        if (status_i.div_done) state_d = S_AT_GO;
      end
      S_AT_GO: begin
        cmd_o.op = OP_AT_GO;
        state_d  = S_DIV_AT;
      end
      S_DIV_AT: begin
        cmd_o.op = OP_DIV_AT;
        if (status_i.div_done) state_d = S_MUL_WL;
      end
      S_MUL_WL: begin
        cmd_o.op = OP_MUL_WL;
        state_d  = S_MUL_WA;
      end
      S_MUL_WA: begin
        cmd_o.op = OP_MUL_WA;
        state_d  = S_W_MAX;
      end
      S_W_MAX: begin
        cmd_o.op = OP_W_MAX;
        state_d  = S_MUL_EXT;
      end
      S_MUL_EXT: begin
        cmd_o.op = OP_MUL_EXT;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV_ANG || state_q == S_DIV_LIN ||
                           state_q == S_DIV_AT))
    else $error("divider finished outside a wait state");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL_DIFF))
    else $error("accepted item did not start the sequence");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !status_i.out_free) |=> (state_q == S_FIN))
    else $error("result dropped while output slot busy");
`endif

endmodule
`default_nettype wire

/* hw/rtl/heading_fsm_weg_drive_controller_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Heading steering and weg extension controller, one control tick per item.
// Channels:
//   s_axis  - one tick: heading angle, measured speed, measured yaw rate.
//   m_axis  - one result per tick: steering mode, both wheel commands and
//             the weg extension setpoint.
//   cfg     - register writes (index, data); always ready, take effect at
//             once. Write only while no tick is in flight.
// A tick occupies the block from one s_axis transfer to the next: three
// passes through the shared bit-serial divider, ten multiply and update
// steps and the idle state that takes the transfer.
// s_axis_tready is high only between ticks.
// The result sits in an output register: the next tick can be accepted
// while it waits, and it is held unchanged until m_axis_tready is seen.
// A stalled receiver holds the block at the end of the following tick.
// Reset: steering mode forward, error averages and previous commands zero,
// registers to their documented defaults; no output is pending.
module heading_fsm_weg_drive_controller_unit
  import hdwc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // heading_angle[15:0], measured_linear_speed[30:16], measured_yaw_rate[46:31]
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // steer_mode[1:0], left_wheel_cmd[17:2], right_wheel_cmd[33:18],
  // extension_target[49:34]
  output logic      [55:0] m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence the tick
  hdwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, state and the output register
  hdwc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire
